// ===== hw/rtl/hri_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// hri_pkg
// Shared constants and types for the Halton radical inverse pipeline.
// ----------------------------------------------------------------------------
package hri_pkg;

    localparam int HRI_INDEX_WIDTH    = 32;
    localparam int HRI_FRACTION_WIDTH = 32;
    localparam int BASE_WIDTH         = 8;
    // quotient bits resolved per digit stage
    localparam int CHUNK_BITS         = 8;
    localparam int ADDR_WIDTH         = 3;
    localparam int DATA_WIDTH         = 32;

    localparam logic [BASE_WIDTH-1:0] MIN_BASE   = 8'd2;
    localparam logic [BASE_WIDTH-1:0] RESET_BASE = 8'd2;

    // register index, taken from paddr[2]
    localparam logic REG_BASE = 1'b0;

    typedef struct packed {
        logic valid;
        logic live;     // index still has digits left
    } hri_ctl_t;

endpackage
`default_nettype wire

// ===== hw/rtl/halton_radical_inverse_unit.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// halton_radical_inverse_unit
// Fully pipelined Halton radical inverse in a programmable integer base.
// ----------------------------------------------------------------------------
// Usage:
//   Pulse start with index; a transaction is taken whenever start is high,
//   since busy stays low. An index of 0 is handled as 1.
//   Each result appears on fraction for one cycle with done high; the
//   receiver must take it then. fraction is an unsigned Q0.FRACTION_WIDTH
//   value equal to floor(R * 2^F / base^m), R being the digit-reversed index.
//   Digit extraction resolves 8 quotient bits of index / base per stage
//   and the final division one bit per stage.
//   Throughput is one transaction per cycle; results leave in order.
//   The base register sits at address 0 of the APB port; writes below 2
//   store 2. Write it only while no transaction is in flight.
//   Reset clears all valid bits and sets base to 2.
// ----------------------------------------------------------------------------
module halton_radical_inverse_unit #(
    parameter int INDEX_WIDTH    = hri_pkg::HRI_INDEX_WIDTH,
    parameter int FRACTION_WIDTH = hri_pkg::HRI_FRACTION_WIDTH
) (
    input  wire                              clk,
    input  wire                              rst_n,
    input  wire                              start,
    output logic                             busy,
    input  wire  [INDEX_WIDTH-1:0]           index,
    output logic                             done,
    output logic [FRACTION_WIDTH-1:0]        fraction,
    input  wire                              psel,
    input  wire                              penable,
    input  wire                              pwrite,
    input  wire  [hri_pkg::ADDR_WIDTH-1:0]   paddr,
    input  wire  [hri_pkg::DATA_WIDTH-1:0]   pwdata,
    output logic [hri_pkg::DATA_WIDTH-1:0]   prdata,
    output logic                             pready
);
    import hri_pkg::*;

    localparam int IW  = INDEX_WIDTH;
    localparam int FW  = FRACTION_WIDTH;
    localparam int BW  = BASE_WIDTH;
    localparam int RW  = IW + BW;
    localparam int CH  = (IW + CHUNK_BITS - 1) / CHUNK_BITS;
    localparam int NS  = IW * CH;
    localparam int LAT = 1 + NS + FW;

    // ---------------- configuration ----------------
    logic [BW-1:0] base_reg, base_next;
    logic          cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == REG_BASE);

    always_comb
    begin
        base_next = base_reg;
        if (cfg_wr)
            base_next = (pwdata[BW-1:0] < MIN_BASE) ? MIN_BASE : pwdata[BW-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            base_reg <= RESET_BASE;
        else
            base_reg <= base_next;
    end

    assign prdata = (paddr[2] == REG_BASE) ? {{(DATA_WIDTH-BW){1'b0}}, base_reg} : '0;

    // ---------------- input register ----------------
    logic          in_valid_reg;
    logic [IW-1:0] in_w_reg;

    assign busy = 1'b0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else
            in_valid_reg <= start && !busy;
    end

    always_ff @(posedge clk)
    begin
        in_w_reg <= (index == '0) ? {{(IW-1){1'b0}}, 1'b1} : index;
    end

    // ---------------- digit extraction ----------------
    hri_ctl_t      dctl [0:NS];
    logic [IW-1:0] dw   [0:NS];
    logic [BW-1:0] drem [0:NS];
    logic [RW-1:0] dr   [0:NS];
    logic [RW-1:0] dbb  [0:NS];

    assign dctl[0].valid = in_valid_reg;
    assign dctl[0].live  = 1'b1;
    assign dw[0]         = in_w_reg;
    assign drem[0]       = '0;
    assign dr[0]         = '0;
    assign dbb[0]        = {{(RW-1){1'b0}}, 1'b1};

    for (genvar s = 0; s < NS; s++)
    begin : g_digit
        localparam int C     = s % CH;
        localparam int STEPS = (C < CH - 1) ? CHUNK_BITS : IW - CHUNK_BITS * (CH - 1);

        hri_digit_stage #(
            .IW    (IW),
            .BW    (BW),
            .RW    (RW),
            .STEPS (STEPS),
            .FIRST (C == 0),
            .LAST  (C == CH - 1)
        ) u_stage (
            .clk     (clk),
            .rst_n   (rst_n),
            .base    (base_reg),
            .ctl_in  (dctl[s]),
            .w_in    (dw[s]),
            .rem_in  (drem[s]),
            .r_in    (dr[s]),
            .bb_in   (dbb[s]),
            .ctl_out (dctl[s+1]),
            .w_out   (dw[s+1]),
            .rem_out (drem[s+1]),
            .r_out   (dr[s+1]),
            .bb_out  (dbb[s+1])
        );
    end

    // ---------------- binary conversion ----------------
    logic          cvalid [0:FW];
    logic [RW-1:0] crem   [0:FW];
    logic [RW-1:0] cdiv   [0:FW];
    logic [FW-1:0] cq     [0:FW];

    assign cvalid[0] = dctl[NS].valid;
    assign crem[0]   = dr[NS];
    assign cdiv[0]   = dbb[NS];
    assign cq[0]     = '0;

    for (genvar k = 0; k < FW; k++)
    begin : g_conv
        hri_conv_stage #(
            .RW (RW),
            .FW (FW)
        ) u_stage (
            .clk       (clk),
            .rst_n     (rst_n),
            .valid_in  (cvalid[k]),
            .rem_in    (crem[k]),
            .div_in    (cdiv[k]),
            .q_in      (cq[k]),
            .valid_out (cvalid[k+1]),
            .rem_out   (crem[k+1]),
            .div_out   (cdiv[k+1]),
            .q_out     (cq[k+1])
        );
    end

    assign done     = cvalid[FW];
    assign fraction = cq[FW];

`ifndef SYNTHESIS
    a_done_has_source: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start, LAT))
        else $error("result without a matching transaction");

    a_start_gives_done: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> ##LAT done)
        else $error("transaction lost in pipeline");

    a_base_legal: assert property (@(posedge clk) disable iff (!rst_n)
        base_reg >= MIN_BASE)
        else $error("base register below minimum");
`endif

endmodule
`default_nettype wire

// ===== hw/rtl/hri_digit_stage.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// hri_digit_stage
// One stage of the digit extractor: a slice of restoring division of the
// remaining index by the base; the last slice of a digit folds the digit
// into the reversed value and the base power.
// ----------------------------------------------------------------------------
module hri_digit_stage #(
    parameter int IW    = 32,
    parameter int BW    = 8,
    parameter int RW    = 40,
    parameter int STEPS = 8,
    parameter bit FIRST = 1'b1,
    parameter bit LAST  = 1'b1
) (
    input  wire                 clk,
    input  wire                 rst_n,
    input  wire  [BW-1:0]       base,
    input  hri_pkg::hri_ctl_t   ctl_in,
    input  wire  [IW-1:0]       w_in,
    input  wire  [BW-1:0]       rem_in,
    input  wire  [RW-1:0]       r_in,
    input  wire  [RW-1:0]       bb_in,
    output hri_pkg::hri_ctl_t   ctl_out,
    output logic [IW-1:0]       w_out,
    output logic [BW-1:0]       rem_out,
    output logic [RW-1:0]       r_out,
    output logic [RW-1:0]       bb_out
);
    import hri_pkg::*;

    hri_ctl_t        ctl_reg, ctl_next;
    logic [IW-1:0]   w_reg, w_next;
    logic [BW-1:0]   rem_reg, rem_next;
    logic [RW-1:0]   r_reg, r_next;
    logic [RW-1:0]   bb_reg, bb_next;
    logic [BW:0]     rem2;
    logic [RW-1:0]   base_ext;
    logic [RW-1:0]   rem_ext;

    always_comb
    begin
        base_ext       = {{(RW-BW){1'b0}}, base};
        ctl_next.valid = ctl_in.valid;
        ctl_next.live  = FIRST ? (w_in != '0) : ctl_in.live;
        rem_next       = FIRST ? '0 : rem_in;
        w_next         = w_in;
        rem2           = '0;
        for (int i = 0; i < STEPS; i++)
        begin
            rem2   = {rem_next, w_next[IW-1]};
            w_next = {w_next[IW-2:0], 1'b0};
            if (rem2 >= {1'b0, base})
            begin
                rem2      = rem2 - {1'b0, base};
                w_next[0] = 1'b1;
            end
            rem_next = rem2[BW-1:0];
        end
        rem_ext = {{(RW-BW){1'b0}}, rem_next};
        r_next  = r_in;
        bb_next = bb_in;
        if (LAST && ctl_next.live)
        begin
            r_next  = (r_in * base_ext) + rem_ext;
            bb_next = bb_in * base_ext;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ctl_reg <= '0;
        else
            ctl_reg <= ctl_next;
    end

    always_ff @(posedge clk)
    begin
        w_reg   <= w_next;
        rem_reg <= rem_next;
        r_reg   <= r_next;
        bb_reg  <= bb_next;
    end

    assign ctl_out = ctl_reg;
    assign w_out   = w_reg;
    assign rem_out = rem_reg;
    assign r_out   = r_reg;
    assign bb_out  = bb_reg;

endmodule
`default_nettype wire

// ===== hw/rtl/hri_conv_stage.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// hri_conv_stage
// One quotient bit of the final division reversed_value * 2^F / base^m.
// ----------------------------------------------------------------------------
module hri_conv_stage #(
    parameter int RW = 40,
    parameter int FW = 32
) (
    input  wire              clk,
    input  wire              rst_n,
    input  wire              valid_in,
    input  wire  [RW-1:0]    rem_in,
    input  wire  [RW-1:0]    div_in,
    input  wire  [FW-1:0]    q_in,
    output logic             valid_out,
    output logic [RW-1:0]    rem_out,
    output logic [RW-1:0]    div_out,
    output logic [FW-1:0]    q_out
);
    logic            valid_reg;
    logic [RW-1:0]   rem_reg, rem_next;
    logic [RW-1:0]   div_reg;
    logic [FW-1:0]   q_reg, q_next;
    logic [RW:0]     rem2;

    // rem_in < div_in always, so the doubled remainder stays below 2*div
    always_comb
    begin
        rem2 = {rem_in, 1'b0};
        if (rem2 >= {1'b0, div_in})
        begin
            rem2   = rem2 - {1'b0, div_in};
            q_next = {q_in[FW-2:0], 1'b1};
        end
        else
        begin
            q_next = {q_in[FW-2:0], 1'b0};
        end
        rem_next = rem2[RW-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_in;
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        div_reg <= div_in;
        q_reg   <= q_next;
    end

    assign valid_out = valid_reg;
    assign rem_out   = rem_reg;
    assign div_out   = div_reg;
    assign q_out     = q_reg;

endmodule
`default_nettype wire

// ===== dv/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Checks the Halton radical inverse unit: indexes go in through the command
// port, and each fraction is compared with a local integer-digit predictor.
// The base register is changed between phases over APB while the unit is idle.
// ----------------------------------------------------------------------------
module tb_top;

    import hri_pkg::*;

    localparam int IW        = HRI_INDEX_WIDTH;
    localparam int FW        = HRI_FRACTION_WIDTH;
    localparam int LATENCY   = 1 + IW * ((IW + 7) / 8) + FW;
    localparam int WDOG_MAX  = 20000;
    localparam int N_RANDOM  = 800;

    typedef struct {
        logic [IW-1:0] idx;
        logic [FW-1:0] want;    // typed-in expectation
        bit            has_want;
    } idx_row_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  start = 1'b0;
    logic                  busy;
    logic [IW-1:0]         index = '0;
    logic                  done;
    logic [FW-1:0]         fraction;
    logic                  psel = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite = 1'b0;
    logic [ADDR_WIDTH-1:0] paddr = '0;
    logic [DATA_WIDTH-1:0] pwdata = '0;
    logic [DATA_WIDTH-1:0] prdata;
    logic                  pready;

    logic [FW-1:0] pending_fractions[$];
    logic [7:0]    cur_base;
    int            fail_count = 0;
    int            idle_cycles = 0;
    int            send_idle_pct = 0;

    halton_radical_inverse_unit dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .index(index),
        .done(done), .fraction(fraction), .psel(psel), .penable(penable),
        .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata), .prdata(prdata),
        .pready(pready)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // digit-reversed fraction by repeated doubling of base-b digits
    function automatic logic [FW-1:0] halton_fraction(logic [IW-1:0] n, logic [7:0] b);
        int unsigned digits[IW];
        int          m;
        int unsigned t;
        bit          carry;
        logic [63:0] rest;
        logic [FW-1:0] acc;
        m = 0;
        acc = '0;
        rest = (n == 0) ? 64'd1 : 64'(n);
        while (rest != 0 && m < IW)
        begin
            digits[m] = int'(rest % b);
            rest = rest / b;
            m++;
        end
        for (int i = 0; i < FW; i++)
        begin
            carry = 1'b0;
            for (int k = m - 1; k >= 0; k--)
            begin
                t = 2 * digits[k] + carry;
                if (t >= b)
                begin
                    digits[k] = t - b;
                    carry = 1'b1;
                end
                else
                begin
                    digits[k] = t;
                    carry = 1'b0;
                end
            end
            acc = {acc[FW-2:0], carry};
        end
        return acc;
    endfunction

    // result checker and watchdog
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((start && !busy) || done)
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (done)
            begin
                if (pending_fractions.size() == 0)
                begin
                    $error("fraction: unexpected transaction, actual %h", fraction);
                    fail_count++;
                end
                else
                begin
                    if (fraction !== pending_fractions[0])
                    begin
                        $error("fraction: expected %h actual %h",
                               pending_fractions[0], fraction);
                        fail_count++;
                    end
                    void'(pending_fractions.pop_front());
                end
            end
            if (idle_cycles >= WDOG_MAX)
            begin
                $display("FAILURE");
                $finish;
            end
        end
    end

    task automatic write_base(logic [DATA_WIDTH-1:0] value);
        logic [7:0] v;
        @(negedge clk);
        psel <= 1'b1;
        pwrite <= 1'b1;
        paddr <= ADDR_WIDTH'(4 * REG_BASE);
        pwdata <= value;
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        v = value[7:0];
        cur_base = (v < MIN_BASE) ? MIN_BASE : v;
    endtask

    // one transaction; start stays high across back-to-back items
    task automatic send_index(logic [IW-1:0] n, logic [FW-1:0] want, bit has_want);
        while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct)
        begin
            start <= 1'b0;
            @(negedge clk);
        end
        start <= 1'b1;
        index <= n;
        do @(posedge clk); while (busy);
        pending_fractions.push_back(has_want ? want : halton_fraction(n, cur_base));
        @(negedge clk);
    endtask

    task automatic drain();
        start <= 1'b0;
        while (pending_fractions.size() != 0)
            @(negedge clk);
        repeat (LATENCY + 4) @(negedge clk);
    endtask

    function automatic logic [IW-1:0] rand_index();
        case ($urandom_range(4))
            0: return IW'($urandom_range(0, 300));
            1: return IW'($urandom);
            2: return {IW{1'b1}} - IW'($urandom_range(0, 255));
            3: return IW'(1) << $urandom_range(0, IW - 1);
            default: return IW'($urandom) >> $urandom_range(0, IW - 1);
        endcase
    endfunction

    idx_row_t directed[] = '{
        '{32'd0,          32'h8000_0000, 1'b1},   // index zero acts as one
        '{32'd1,          32'h8000_0000, 1'b1},
        '{32'd2,          32'h4000_0000, 1'b1},
        '{32'd3,          32'hC000_0000, 1'b1},
        '{32'h8000_0000,  32'h0000_0001, 1'b1},
        '{32'hFFFF_FFFF,  32'hFFFF_FFFF, 1'b1},
        '{32'h5555_5555,  32'h0,         1'b0},
        '{32'hAAAA_AAAA,  32'h0,         1'b0},
        '{32'd255,        32'h0,         1'b0},
        '{32'd256,        32'h0,         1'b0}
    };

    logic [DATA_WIDTH-1:0] base_plan[] = '{
        32'd0, 32'd1, 32'd255, 32'd3, 32'hFFFF_FF07, 32'd16, 32'd254, 32'd2
    };
    int idle_plan[] = '{0, 66, 21, 0};

    initial
    begin
        cur_base = RESET_BASE;
        repeat (11) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (directed[i])
            send_index(directed[i].idx, directed[i].want, directed[i].has_want);
        // pause until every result is back
        drain();

        foreach (base_plan[p])
        begin
            write_base(base_plan[p]);
            send_index(32'd0, 32'h0, 1'b0);
            send_index({IW{1'b1}}, 32'h0, 1'b0);
            send_index(IW'(cur_base), 32'h0, 1'b0);
            send_index(IW'(cur_base) - 1, 32'h0, 1'b0);
            for (int j = 0; j < N_RANDOM / base_plan.size(); j++)
            begin
                send_idle_pct = idle_plan[(p + j / 25) % idle_plan.size()];
                send_index(rand_index(), 32'h0, 1'b0);
            end
            send_idle_pct = 0;
            drain();
        end

        if (fail_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
